FILE: design/column_mean_stddev_macros.svh
// assertion macros for the column statistics block
`ifndef COLUMN_MEAN_STDDEV_MACROS_SVH
`define COLUMN_MEAN_STDDEV_MACROS_SVH
`ifndef SYNTHESIS
`define CMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("column_mean_stddev: same-cycle check failed");
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("column_mean_stddev: next-cycle check failed");
`else
`define CMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/cms_pkg.sv
package cms_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned SUM_W         = 24;
  localparam int unsigned SQ_W          = 40;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned COL_W         = 2;
  localparam int unsigned NUM_COLS      = 3;
  localparam int unsigned MAX_ITEMS_DEF = 128;
  // width of n*sumsq, sum^2, their difference and the quotient
  localparam int unsigned WIDE_W        = 48;
  localparam int unsigned DVS_W         = 16;
  localparam int unsigned REM_W         = 17;
  localparam int unsigned DIV_STEPS     = 48;
  localparam int unsigned SQRT_STEPS    = 24;
  localparam int unsigned STEP_W        = 6;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLS - 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;
    logic [SAMPLE_W-1:0] sample_third;
    logic                is_final_row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]    column_index;
    logic [SAMPLE_W-1:0] column_mean;
    logic [SAMPLE_W-1:0] column_deviation;
    logic [CNT_W-1:0]    rows_counted;
    logic                overflow_flag;
    logic                end_of_run;
  } out_item_t;

  typedef struct packed {
    logic             accept;
    logic             prep;
    logic             div_step;
    logic             load_dev;
    logic             load_root;
    logic             sqrt_step;
    logic             load_out;
    logic             clear;
    logic [COL_W-1:0] col;
  } cms_cmd_t;

endpackage

FILE: design/cms_datapath.sv
module cms_datapath #(
  parameter int unsigned MAX_ITEMS = cms_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cms_pkg::in_item_t  in_data,
  input  cms_pkg::cms_cmd_t  cmd,
  output cms_pkg::out_item_t out_data
);

  // accumulators
  logic [cms_pkg::CNT_W-1:0]  cnt_r;
  logic [cms_pkg::SUM_W-1:0]  sum_r [cms_pkg::NUM_COLS];
  logic [cms_pkg::SQ_W-1:0]   sq_r  [cms_pkg::NUM_COLS];
  logic                       drop_r;

  // working registers
  logic [cms_pkg::WIDE_W-1:0] a_r, b_r, q_r, rv_r, res_r, bit_r;
  logic [cms_pkg::DVS_W-1:0]  nn_r, dvs_r;
  logic [cms_pkg::REM_W-1:0]  rem_r;
  logic [cms_pkg::SAMPLE_W-1:0] mean_r;
  cms_pkg::out_item_t         out_data_r;

  logic [cms_pkg::SAMPLE_W-1:0] smp [cms_pkg::NUM_COLS];
  logic [2*cms_pkg::SAMPLE_W-1:0] sqr [cms_pkg::NUM_COLS];
  logic                       has_room;
  logic [cms_pkg::SUM_W-1:0]  sum_sel;
  logic [cms_pkg::SQ_W-1:0]   sq_sel;
  logic [cms_pkg::WIDE_W-1:0] a_prod, b_prod;
  logic [cms_pkg::DVS_W-1:0]  nn_prod;
  logic [cms_pkg::REM_W-1:0]  rem_sh, rem_new;
  logic                       div_ge;
  logic [cms_pkg::WIDE_W-1:0] trial;
  logic                       sq_ge;
  logic                       empty;

  assign smp[0] = in_data.sample_first;
  assign smp[1] = in_data.sample_second;
  assign smp[2] = in_data.sample_third;

  always_comb begin
    for (int c = 0; c < cms_pkg::NUM_COLS; c++) begin
      sqr[c] = smp[c] * smp[c];
    end
  end

  assign has_room = cnt_r < cms_pkg::CNT_W'(MAX_ITEMS);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      for (int c = 0; c < cms_pkg::NUM_COLS; c++) begin
        sum_r[c] <= '0;
        sq_r[c]  <= '0;
      end
    end else if (cmd.accept) begin
      if (has_room) begin
        for (int c = 0; c < cms_pkg::NUM_COLS; c++) begin
          sum_r[c] <= sum_r[c] + cms_pkg::SUM_W'(smp[c]);
          sq_r[c]  <= sq_r[c] + cms_pkg::SQ_W'(sqr[c]);
        end
        cnt_r <= cnt_r + 1'b1;
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  assign sum_sel = sum_r[cmd.col];
  assign sq_sel  = sq_r[cmd.col];
  assign a_prod  = cms_pkg::WIDE_W'(cnt_r) * cms_pkg::WIDE_W'(sq_sel);
  assign b_prod  = cms_pkg::WIDE_W'(sum_sel) * cms_pkg::WIDE_W'(sum_sel);
  assign nn_prod = cms_pkg::DVS_W'(cnt_r) * cms_pkg::DVS_W'(cnt_r);

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r[cms_pkg::REM_W-2:0], q_r[cms_pkg::WIDE_W-1]};
  assign div_ge  = rem_sh >= cms_pkg::REM_W'(dvs_r);
  assign rem_new = div_ge ? rem_sh - cms_pkg::REM_W'(dvs_r) : rem_sh;

  // digit-by-digit square root, two radicand bits a cycle
  assign trial = res_r + bit_r;
  assign sq_ge = rv_r >= trial;

  assign empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      a_r   <= a_prod;
      b_r   <= b_prod;
      nn_r  <= nn_prod;
      q_r   <= cms_pkg::WIDE_W'(sum_sel);
      rem_r <= '0;
      dvs_r <= cms_pkg::DVS_W'(cnt_r);
    end
    if (cmd.div_step) begin
      rem_r <= rem_new;
      q_r   <= {q_r[cms_pkg::WIDE_W-2:0], div_ge};
    end
    if (cmd.load_dev) begin
      mean_r <= q_r[cms_pkg::SAMPLE_W-1:0];
      q_r    <= (a_r > b_r) ? a_r - b_r : '0;
      rem_r  <= '0;
      dvs_r  <= nn_r;
    end
    if (cmd.load_root) begin
      rv_r  <= q_r;
      res_r <= '0;
      bit_r <= cms_pkg::WIDE_W'(1) << (cms_pkg::WIDE_W - 2);
    end
    if (cmd.sqrt_step) begin
      if (sq_ge) begin
        rv_r  <= rv_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.load_out) begin
      out_data_r.column_index     <= cmd.col;
      out_data_r.column_mean      <= empty ? '0 : mean_r;
      out_data_r.column_deviation <= empty ? '0 : res_r[cms_pkg::SAMPLE_W-1:0];
      out_data_r.rows_counted     <= cnt_r;
      out_data_r.overflow_flag    <= drop_r;
      out_data_r.end_of_run       <= cmd.col == cms_pkg::LAST_COL;
    end
  end

  assign out_data = out_data_r;

endmodule

FILE: design/cms_ctrl.sv
`include "column_mean_stddev_macros.svh"

module cms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_final,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output cms_pkg::cms_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_DIVM  = 3'd2;
  localparam logic [2:0] ST_LOADD = 3'd3;
  localparam logic [2:0] ST_DIVD  = 3'd4;
  localparam logic [2:0] ST_LOADS = 3'd5;
  localparam logic [2:0] ST_SQRT  = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [cms_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [cms_pkg::COL_W-1:0]   col_r, col_nxt;
  logic                        out_valid_r, out_valid_nxt;

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    cmd          = '0;
    cmd.col      = col_r;
    cmd.accept   = in_valid && (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && in_final) begin
          state_nxt = ST_PREP;
          col_nxt   = '0;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIVM;
      end
      ST_DIVM: begin
        cmd.div_step = 1'b1;
        if (cnt_r == cms_pkg::STEP_W'(cms_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_LOADD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LOADD: begin
        cmd.load_dev = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.div_step = 1'b1;
        if (cnt_r == cms_pkg::STEP_W'(cms_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_LOADS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LOADS: begin
        cmd.load_root = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == cms_pkg::STEP_W'(cms_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          if (col_r == cms_pkg::LAST_COL) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = ST_PREP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CMS_ASSERT_NEXT(a_final_row_stalls, clk, rst_n, cmd.accept && in_final, in_stall)
  `CMS_ASSERT_NEXT(a_run_done_idle, clk, rst_n, cmd.load_out && cmd.col == cms_pkg::LAST_COL, !in_stall && !cmd.prep)
  `CMS_ASSERT_IMPLY(a_one_command, clk, rst_n, 1'b1, $onehot0({cmd.prep, cmd.div_step, cmd.load_dev, cmd.load_root, cmd.sqrt_step, cmd.load_out, cmd.accept}))
  `CMS_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.load_out && out_valid_r, !out_stall)

endmodule

FILE: design/column_mean_stddev.sv
// rows that are not marked final are taken back to back, one row a cycle
// a final row then stalls the input while, for each of the 3 columns, the block forms the products,
// runs 48 + 48 steps of the shared bit-serial divider, 24 square root steps and 3 moves
// the results are registered one column at a time; a result held stalled at the output holds the next
// rst_n is synchronous, active low, and clears the controller, the output valid
// and all counts and sums; counts and sums alone are cleared again with the third result of a run
module column_mean_stddev #(
  parameter int unsigned MAX_ITEMS = cms_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cms_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cms_pkg::out_item_t out_data
);

  // command bundle from the controller into the datapath
  cms_pkg::cms_cmd_t cmd;

  // controller: accepts rows while idle, then sequences divider and root per column
  cms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_data.is_final_row),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: accumulators, shared divider, square root unit and output register
  cms_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cms_pkg::*;

  // capacity of the block as instantiated, also used by the prediction
  localparam int unsigned ROW_CAPACITY = MAX_ITEMS_DEF;

  // running column statistics, predicted results and their comparison
  class column_stats_tracker;
    logic [CNT_W-1:0] rows_held;
    logic [SUM_W-1:0] col_total [NUM_COLS];
    logic [SQ_W-1:0]  col_energy [NUM_COLS];
    bit               rows_lost;
    out_item_t        awaited_stats [$];
    int               failures;

    function new();
      failures = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      rows_held = '0;
      rows_lost = 1'b0;
      for (int c = 0; c < NUM_COLS; c++) begin
        col_total[c]  = '0;
        col_energy[c] = '0;
      end
    endfunction

    // floor square root, one result bit at a time from the top
    function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function void note_row(in_item_t row);
      logic [SAMPLE_W-1:0] s [NUM_COLS];
      logic [63:0]         n;
      logic [63:0]         tot;
      logic [63:0]         scaled_sq;
      logic [63:0]         tot_sq;
      logic [63:0]         spread;
      out_item_t           stats;
      s[0] = row.sample_first;
      s[1] = row.sample_second;
      s[2] = row.sample_third;
      if (rows_held < ROW_CAPACITY) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          col_total[c]  = col_total[c] + SUM_W'(s[c]);
          col_energy[c] = col_energy[c] + SQ_W'(s[c]) * SQ_W'(s[c]);
        end
        rows_held = rows_held + 1'b1;
      end else begin
        rows_lost = 1'b1;
      end
      if (!row.is_final_row) return;
      n = 64'(rows_held);
      for (int c = 0; c < NUM_COLS; c++) begin
        tot       = 64'(col_total[c]);
        scaled_sq = n * 64'(col_energy[c]);
        tot_sq    = tot * tot;
        spread    = (scaled_sq > tot_sq) ? scaled_sq - tot_sq : 64'd0;
        stats.column_index     = COL_W'(c);
        stats.column_mean      = (n != 0) ? SAMPLE_W'(tot / n) : '0;
        stats.column_deviation = (n != 0) ? SAMPLE_W'(floor_root(spread / (n * n))) : '0;
        stats.rows_counted     = rows_held;
        stats.overflow_flag    = rows_lost;
        stats.end_of_run       = (COL_W'(c) == LAST_COL);
        awaited_stats.push_back(stats);
      end
      clear_sums();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_stats(out_item_t got);
      out_item_t want;
      if (awaited_stats.size() == 0) begin
        $error("column result with none awaited: column %0d", got.column_index);
        failures++;
        return;
      end
      want = awaited_stats.pop_front();
      compare_field("column_index", want.column_index, got.column_index);
      compare_field("column_mean", want.column_mean, got.column_mean);
      compare_field("column_deviation", want.column_deviation, got.column_deviation);
      compare_field("rows_counted", want.rows_counted, got.rows_counted);
      compare_field("overflow_flag", want.overflow_flag, got.overflow_flag);
      compare_field("end_of_run", want.end_of_run, got.end_of_run);
    endfunction

    function int pending();
      return awaited_stats.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  column_stats_tracker board;
  // when set, neither side idles: gives a long unbroken stretch of traffic
  bit steady;
  int rows_sent;

  column_mean_stddev #(
    .MAX_ITEMS(ROW_CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both channels sampled at the rising edge; inputs only move on the falling one
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_row(in_data);
    if (rst_n && out_valid && !out_stall) board.check_stats(out_data);
  end

  // result side holds off in roughly one cycle of ten, except in steady stretches
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 10);
  end

  function automatic in_item_t make_row(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                        logic last);
    in_item_t row;
    row.sample_first  = a;
    row.sample_second = b;
    row.sample_third  = c;
    row.is_final_row  = last;
    return row;
  endfunction

  // one row onto the input channel, with an occasional gap before it,
  // returning once the block has taken it
  task automatic send_row(in_item_t row);
    if (!steady && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= row;
    do @(posedge clk); while (in_stall);
    rows_sent++;
  endtask

  // half of them full-range values, some extremes and some clustered round a centre
  // so that small deviations turn up as well as large ones
  function automatic logic [15:0] pick_sample(logic [15:0] centre);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return centre + 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // one data set of the given number of rows, the last one marked final
  task automatic send_set(int len);
    logic [15:0] centre [3];
    for (int c = 0; c < 3; c++) centre[c] = 16'($urandom_range(0, 65535));
    for (int i = 0; i < len; i++) begin
      send_row(make_row(pick_sample(centre[0]), pick_sample(centre[1]),
                        pick_sample(centre[2]), i == len - 1));
    end
  endtask

  // sender goes quiet until every awaited column result has arrived
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  initial begin
    board     = new();
    steady    = 1'b0;
    rows_sent = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // a lone row: mean is the sample itself, deviation zero
    send_row(make_row(16'h1234, 16'h0000, 16'hFFFF, 1'b1));
    // two rows at opposite extremes in the first two columns: largest possible spread
    send_row(make_row(16'h0000, 16'hFFFF, 16'h8000, 1'b0));
    send_row(make_row(16'hFFFF, 16'h0000, 16'h8000, 1'b1));
    // all full scale
    repeat (3) send_row(make_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_row(make_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // all zero
    repeat (2) send_row(make_row(16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_row(make_row(16'h0000, 16'h0000, 16'h0000, 1'b1));
    // close values: deviation below one lsb of the integer part
    send_row(make_row(16'h0100, 16'h7FFF, 16'h0001, 1'b0));
    send_row(make_row(16'h0101, 16'h8000, 16'h0002, 1'b0));
    send_row(make_row(16'h0102, 16'h8001, 16'h0003, 1'b1));
    // walking ones, each column through its own bits, together every sample bit
    for (int k = 0; k < 6; k++) begin
      send_row(make_row(16'd1 << k, 16'd1 << (k + 6), 16'd1 << (k + 10), k == 5));
    end

    // hold off until the block has emptied out
    drain();

    while (rows_sent < 150) begin
      send_set($urandom_range(1, 10));
      if ($urandom_range(0, 7) == 0) drain();
    end

    // a full set with the final row as the last one that fits, no idling
    steady = 1'b1;
    send_set(ROW_CAPACITY);
    steady = 1'b0;
    // past capacity: the extra rows and the final one are dropped and flagged
    send_set(ROW_CAPACITY + 3);

    while (rows_sent < 410) begin
      send_set($urandom_range(1, 10));
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    // room for any stray result
    repeat (400) @(posedge clk);
    if (board.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ends the test as a mismatch if it runs far longer than the slowest run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/cms_pkg.sv
design/cms_datapath.sv
design/cms_ctrl.sv
design/column_mean_stddev.sv
test/tb_top.sv
